@@ hdl/assert_macros.svh @@
// assertion macros used by the address generator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ hdl/mag_pkg.sv @@
// types and operation codes of the matrix operation address generator
`default_nettype none

package mag_pkg;

    localparam int KIND_W  = 6;
    localparam int IDX_W   = 6;
    localparam int RED_W   = 7;
    localparam int LAT_W   = 4;
    localparam int COORD_W = 7;
    localparam int ADDR_W  = 12;

    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [RED_W-1:0]   red_idx_t;
    typedef logic [LAT_W-1:0]   lat_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    typedef struct packed {
        logic  load0_valid;
        addr_t load0_address;
        logic  load1_valid;
        addr_t load1_address;
        logic  store_valid;
        logic  store_to_reducer;
        addr_t store_address;
    } addr_set_t;

    localparam kind_t OP_MULMM    = 6'd0;
    localparam kind_t OP_MULMV    = 6'd1;
    localparam kind_t OP_MULSM    = 6'd2;
    localparam kind_t OP_MULTRMM  = 6'd3;
    localparam kind_t OP_MULTRMV  = 6'd4;
    localparam kind_t OP_ADDTRM   = 6'd5;
    localparam kind_t OP_MULTRSM  = 6'd6;
    localparam kind_t OP_DIVMS    = 6'd7;
    localparam kind_t OP_TRM      = 6'd8;
    localparam kind_t OP_ADDM     = 6'd9;
    localparam kind_t OP_SUBM     = 6'd10;
    localparam kind_t OP_PMULM    = 6'd11;
    localparam kind_t OP_ADDV     = 6'd12;
    localparam kind_t OP_SUBV     = 6'd13;
    localparam kind_t OP_PMULV    = 6'd14;
    localparam kind_t OP_MULSV    = 6'd15;
    localparam kind_t OP_DIVVS    = 6'd16;
    localparam kind_t OP_MULS     = 6'd17;
    localparam kind_t OP_ADDS     = 6'd18;
    localparam kind_t OP_SUBS     = 6'd19;
    localparam kind_t OP_OPRODV   = 6'd20;
    localparam kind_t OP_SUBCMV   = 6'd21;
    localparam kind_t OP_DIVCMV   = 6'd22;
    localparam kind_t OP_ACCSUMCM = 6'd23;
    localparam kind_t OP_ABSM     = 6'd24;
    localparam kind_t OP_SET0M    = 6'd25;
    localparam kind_t OP_SETIDM   = 6'd26;
    localparam kind_t OP_ABSV     = 6'd27;
    localparam kind_t OP_SQRTV    = 6'd28;
    localparam kind_t OP_CUTMINV  = 6'd29;
    localparam kind_t OP_COPYV    = 6'd30;
    localparam kind_t OP_ABSS     = 6'd31;
    localparam kind_t OP_SQRTS    = 6'd32;
    localparam kind_t OP_SETD1    = 6'd33;
    localparam kind_t OP_DOTV     = 6'd34;
    localparam kind_t OP_SASUM    = 6'd35;
    localparam kind_t OP_NOOP     = 6'd36;

endpackage

`default_nettype wire

@@ hdl/mag_decode.sv @@
// operation decode and row-major address computation
`default_nettype none

module mag_decode #(
    parameter int DIM = 64
) (
    input  wire mag_pkg::kind_t    kind,
    input  wire mag_pkg::idx_t     row_idx,
    input  wire mag_pkg::idx_t     mid_idx,
    input  wire mag_pkg::idx_t     col_idx,
    input  wire mag_pkg::red_idx_t reduce_idx,
    input  wire mag_pkg::lat_t     latency_step,
    output mag_pkg::addr_set_t     result
);

    localparam mag_pkg::addr_t DIM_A = mag_pkg::ADDR_W'(DIM);

    mag_pkg::coord_t i_c;
    mag_pkg::coord_t j_c;
    mag_pkg::coord_t k_c;
    mag_pkg::coord_t e_c;
    mag_pkg::addr_t  e_a;
    logic            i0;
    logic            ij0;
    logic            ijk0;
    logic            upper;
    logic            red;
    logic            red_last;

    logic            ld0_en;
    logic            ld1_en;
    logic            st_en;
    logic            st_red;
    mag_pkg::coord_t ld0_r;
    mag_pkg::coord_t ld0_c;
    mag_pkg::coord_t ld1_r;
    mag_pkg::coord_t ld1_c;
    mag_pkg::coord_t st_r;
    mag_pkg::coord_t st_c;

    function automatic mag_pkg::addr_t place(mag_pkg::coord_t r, mag_pkg::coord_t c);
        mag_pkg::addr_t r_a;
        mag_pkg::addr_t c_a;
        r_a   = {{(mag_pkg::ADDR_W - mag_pkg::COORD_W){1'b0}}, r};
        c_a   = {{(mag_pkg::ADDR_W - mag_pkg::COORD_W){1'b0}}, c};
        place = r_a * DIM_A + c_a;
    endfunction

    assign i_c      = {1'b0, row_idx};
    assign j_c      = {1'b0, mid_idx};
    assign k_c      = {1'b0, col_idx};
    assign e_c      = reduce_idx;
    assign e_a      = {{(mag_pkg::ADDR_W - mag_pkg::RED_W){1'b0}}, reduce_idx};
    assign i0       = (row_idx == '0);
    assign ij0      = i0 && (mid_idx == '0);
    assign ijk0     = ij0 && (col_idx == '0);
    assign upper    = (col_idx >= mid_idx);
    assign red      = (latency_step == '0) && (e_a < DIM_A);
    assign red_last = !((e_a + mag_pkg::ADDR_W'(1)) < DIM_A);

    always_comb
    begin
        ld0_en = 1'b0;
        ld1_en = 1'b0;
        st_en  = 1'b0;
        st_red = 1'b0;
        ld0_r  = '0;
        ld0_c  = '0;
        ld1_r  = '0;
        ld1_c  = '0;
        st_r   = '0;
        st_c   = '0;
        unique case (kind) inside
            mag_pkg::OP_MULMM:
            begin
                ld0_en = 1'b1; ld0_r = i_c; ld0_c = j_c;
                ld1_en = 1'b1; ld1_r = j_c; ld1_c = k_c;
                st_en  = 1'b1; st_r  = i_c; st_c  = k_c;
            end
            mag_pkg::OP_MULMV:
            begin
                ld0_en = i0; ld0_r = k_c; ld0_c = j_c;
                ld1_en = i0; ld1_c = j_c;
                st_en  = i0; st_r  = j_c; st_c  = k_c;
            end
            mag_pkg::OP_MULSM:
            begin
                ld0_en = i0;
                ld1_en = i0; ld1_r = j_c; ld1_c = k_c;
                st_en  = i0; st_r  = j_c; st_c  = k_c;
            end
            mag_pkg::OP_MULTRMM:
            begin
                ld0_en = upper; ld0_r = i_c; ld0_c = j_c;
                ld1_en = upper; ld1_r = j_c; ld1_c = k_c;
                st_en  = upper; st_r  = i_c; st_c  = k_c;
            end
            mag_pkg::OP_MULTRMV:
            begin
                ld0_en = i0 && upper; ld0_r = k_c; ld0_c = j_c;
                ld1_en = i0 && upper; ld1_c = j_c;
                st_en  = i0 && upper; st_r  = j_c; st_c  = k_c;
            end
            mag_pkg::OP_ADDTRM:
            begin
                ld0_en = i0 && upper; ld0_r = j_c; ld0_c = k_c;
                ld1_en = i0 && upper; ld1_r = j_c; ld1_c = k_c;
                st_en  = i0 && upper; st_r  = j_c; st_c  = k_c;
            end
            mag_pkg::OP_MULTRSM:
            begin
                ld0_en = i0 && upper;
                ld1_en = i0 && upper; ld1_r = j_c; ld1_c = k_c;
                st_en  = i0 && upper; st_r  = j_c; st_c  = k_c;
            end
            mag_pkg::OP_DIVMS:
            begin
                ld0_en = i0; ld0_r = j_c; ld0_c = k_c;
                ld1_en = i0;
                st_en  = i0; st_r  = j_c; st_c  = k_c;
            end
            mag_pkg::OP_TRM:
            begin
                ld0_en = i0; ld0_r = j_c; ld0_c = k_c;
                st_en  = i0; st_r  = k_c; st_c  = j_c;
            end
            mag_pkg::OP_ADDM, mag_pkg::OP_SUBM, mag_pkg::OP_PMULM:
            begin
                ld0_en = i0; ld0_r = j_c; ld0_c = k_c;
                ld1_en = i0; ld1_r = j_c; ld1_c = k_c;
                st_en  = i0; st_r  = j_c; st_c  = k_c;
            end
            mag_pkg::OP_ADDV, mag_pkg::OP_SUBV, mag_pkg::OP_PMULV:
            begin
                ld0_en = ij0; ld0_c = k_c;
                ld1_en = ij0; ld1_c = k_c;
                st_en  = ij0; st_c  = k_c;
            end
            mag_pkg::OP_MULSV:
            begin
                ld0_en = ij0;
                ld1_en = ij0; ld1_c = k_c;
                st_en  = ij0; st_c  = k_c;
            end
            mag_pkg::OP_DIVVS:
            begin
                ld0_en = ij0; ld0_c = k_c;
                ld1_en = ij0;
                st_en  = ij0; st_c  = k_c;
            end
            mag_pkg::OP_MULS, mag_pkg::OP_ADDS, mag_pkg::OP_SUBS:
            begin
                ld0_en = ijk0;
                ld1_en = ijk0;
                st_en  = ijk0;
            end
            mag_pkg::OP_OPRODV:
            begin
                ld0_en = i0; ld0_c = j_c;
                ld1_en = i0; ld1_c = k_c;
                st_en  = i0; st_r  = j_c; st_c = k_c;
            end
            mag_pkg::OP_SUBCMV, mag_pkg::OP_DIVCMV:
            begin
                ld0_en = i0; ld0_r = j_c; ld0_c = k_c;
                ld1_en = i0; ld1_c = k_c;
                st_en  = i0; st_r  = j_c; st_c  = k_c;
            end
            mag_pkg::OP_ACCSUMCM:
            begin
                ld0_en = i0; ld0_r = j_c; ld0_c = k_c;
                st_en  = i0; st_c  = k_c;
            end
            mag_pkg::OP_ABSM, mag_pkg::OP_SETD1:
            begin
                ld0_en = i0; ld0_r = j_c; ld0_c = k_c;
                st_en  = i0; st_r  = j_c; st_c  = k_c;
            end
            mag_pkg::OP_SET0M, mag_pkg::OP_SETIDM:
            begin
                st_en = i0; st_r = j_c; st_c = k_c;
            end
            mag_pkg::OP_ABSV, mag_pkg::OP_SQRTV, mag_pkg::OP_CUTMINV, mag_pkg::OP_COPYV:
            begin
                ld0_en = ij0; ld0_c = k_c;
                st_en  = ij0; st_c  = k_c;
            end
            mag_pkg::OP_ABSS, mag_pkg::OP_SQRTS:
            begin
                ld0_en = ijk0;
                st_en  = ijk0;
            end
            mag_pkg::OP_DOTV:
            begin
                ld0_en = red; ld0_c = e_c;
                ld1_en = red; ld1_c = e_c;
                st_en  = red;
                st_red = red && !red_last;
            end
            mag_pkg::OP_SASUM:
            begin
                ld0_en = red; ld0_c = e_c;
                st_en  = red;
                st_red = red && !red_last;
            end
            default:
            begin
                ld0_en = 1'b0;
            end
        endcase
    end

    // unused ports and the reduction register target read as zero address
    always_comb
    begin
        result.load0_valid      = ld0_en;
        result.load0_address    = ld0_en ? place(ld0_r, ld0_c) : '0;
        result.load1_valid      = ld1_en;
        result.load1_address    = ld1_en ? place(ld1_r, ld1_c) : '0;
        result.store_valid      = st_en;
        result.store_to_reducer = st_red;
        result.store_address    = (st_en && !st_red) ? place(st_r, st_c) : '0;
    end

endmodule

`default_nettype wire

@@ hdl/matrix_op_address_generator.sv @@
// each item is captured in the input register, then decoded into the output register
// throughput: one item per cycle while out_stall is low; the address set per item needs three small
// multiplies by DIM in the single decode stage between input and output registers
// the input register keeps taking items while a result waits, until both hold data
// reset: asynchronous, active low, empties both the input and output registers
`default_nettype none
`include "assert_macros.svh"

module matrix_op_address_generator #(
    parameter int DIM = 64
) (
    input  wire                    clk,
    input  wire                    rst_n,

    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire mag_pkg::kind_t    kind,
    input  wire mag_pkg::idx_t     row_idx,
    input  wire mag_pkg::idx_t     mid_idx,
    input  wire mag_pkg::idx_t     col_idx,
    input  wire mag_pkg::red_idx_t reduce_idx,
    input  wire mag_pkg::lat_t     latency_step,

    output logic                   out_valid,
    input  wire                    out_stall,
    output logic                   load0_valid,
    output mag_pkg::addr_t         load0_address,
    output logic                   load1_valid,
    output mag_pkg::addr_t         load1_address,
    output logic                   store_valid,
    output logic                   store_to_reducer,
    output mag_pkg::addr_t         store_address
);

    logic               s1_valid_reg;
    mag_pkg::kind_t     kind_reg;
    mag_pkg::idx_t      row_reg;
    mag_pkg::idx_t      mid_reg;
    mag_pkg::idx_t      col_reg;
    mag_pkg::red_idx_t  red_reg;
    mag_pkg::lat_t      lat_reg;

    logic               out_valid_reg;
    mag_pkg::addr_set_t res_reg;
    mag_pkg::addr_set_t res_next;

    logic               out_free;
    logic               in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || out_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind;
            row_reg  <= row_idx;
            mid_reg  <= mid_idx;
            col_reg  <= col_idx;
            red_reg  <= reduce_idx;
            lat_reg  <= latency_step;
        end
        if (out_free && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    mag_decode #(
        .DIM (DIM)
    ) u_decode (
        .kind         (kind_reg),
        .row_idx      (row_reg),
        .mid_idx      (mid_reg),
        .col_idx      (col_reg),
        .reduce_idx   (red_reg),
        .latency_step (lat_reg),
        .result       (res_next)
    );

    assign out_valid        = out_valid_reg;
    assign load0_valid      = res_reg.load0_valid;
    assign load0_address    = res_reg.load0_address;
    assign load1_valid      = res_reg.load1_valid;
    assign load1_address    = res_reg.load1_address;
    assign store_valid      = res_reg.store_valid;
    assign store_to_reducer = res_reg.store_to_reducer;
    assign store_address    = res_reg.store_address;

    `ASSERT_PROP(a_reducer_store, clk, rst_n, (out_valid && store_to_reducer) |-> (store_valid && (store_address == '0)), "reducer store without store or with address")
    `ASSERT_PROP(a_unused_load0, clk, rst_n, (out_valid && !load0_valid) |-> (load0_address == '0), "unused load0 port carries an address")
    `ASSERT_PROP(a_stall_needs_data, clk, rst_n, in_stall |-> (s1_valid_reg && out_valid_reg), "input stalled with a free register")
    `ASSERT_PROP(a_full_blocks, clk, rst_n, (s1_valid_reg && out_valid_reg && out_stall) |-> in_stall, "input taken while both registers are held")

endmodule

`default_nettype wire

@@ bench/mag_addr_checker.sv @@
`timescale 1ns / 1ps
// checker that predicts and compares the address sets of the matrix operation address generator
module mag_addr_checker #(
    parameter int DIM = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  mag_pkg::kind_t    kind,
    input  mag_pkg::idx_t     row_idx,
    input  mag_pkg::idx_t     mid_idx,
    input  mag_pkg::idx_t     col_idx,
    input  mag_pkg::red_idx_t reduce_idx,
    input  mag_pkg::lat_t     latency_step,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              load0_valid,
    input  mag_pkg::addr_t    load0_address,
    input  logic              load1_valid,
    input  mag_pkg::addr_t    load1_address,
    input  logic              store_valid,
    input  logic              store_to_reducer,
    input  mag_pkg::addr_t    store_address,
    output int                fail_count,
    output int                pending_results
);

    mag_pkg::addr_set_t expected_sets[$];

    function automatic mag_pkg::addr_t grid_address(int r, int c);
        logic [31:0] flat;
        flat = r * DIM + c;
        return flat[mag_pkg::ADDR_W-1:0];
    endfunction

    function automatic mag_pkg::addr_set_t pack_set(int use0, int r0, int c0,
                                                    int use1, int r1, int c1,
                                                    int use_st, int rs, int cs);
        mag_pkg::addr_set_t s;
        s = '0;
        if (use0 != 0)
        begin
            s.load0_valid   = 1'b1;
            s.load0_address = grid_address(r0, c0);
        end
        if (use1 != 0)
        begin
            s.load1_valid   = 1'b1;
            s.load1_address = grid_address(r1, c1);
        end
        if (use_st != 0)
        begin
            s.store_valid   = 1'b1;
            s.store_address = grid_address(rs, cs);
        end
        return s;
    endfunction

    function automatic mag_pkg::addr_set_t expected_addr_set(mag_pkg::kind_t op,
                                                             mag_pkg::idx_t i_in,
                                                             mag_pkg::idx_t j_in,
                                                             mag_pkg::idx_t k_in,
                                                             mag_pkg::red_idx_t e_in,
                                                             mag_pkg::lat_t lat);
        mag_pkg::addr_set_t s;
        int i;
        int j;
        int k;
        int e;
        bit row0;
        bit plane0;
        bit all0;
        bit upper;
        bit red_on;
        i      = int'(i_in);
        j      = int'(j_in);
        k      = int'(k_in);
        e      = int'(e_in);
        s      = '0;
        row0   = (i == 0);
        plane0 = row0 && (j == 0);
        all0   = plane0 && (k == 0);
        upper  = (k >= j);
        red_on = (lat == '0) && (e < DIM);
        case (op)
            mag_pkg::OP_MULMM:
                s = pack_set(1, i, j, 1, j, k, 1, i, k);
            mag_pkg::OP_MULMV:
                if (row0) s = pack_set(1, k, j, 1, 0, j, 1, j, k);
            mag_pkg::OP_MULSM:
                if (row0) s = pack_set(1, 0, 0, 1, j, k, 1, j, k);
            mag_pkg::OP_MULTRMM:
                if (upper) s = pack_set(1, i, j, 1, j, k, 1, i, k);
            mag_pkg::OP_MULTRMV:
                if (row0 && upper) s = pack_set(1, k, j, 1, 0, j, 1, j, k);
            mag_pkg::OP_ADDTRM:
                if (row0 && upper) s = pack_set(1, j, k, 1, j, k, 1, j, k);
            mag_pkg::OP_MULTRSM:
                if (row0 && upper) s = pack_set(1, 0, 0, 1, j, k, 1, j, k);
            mag_pkg::OP_DIVMS:
                if (row0) s = pack_set(1, j, k, 1, 0, 0, 1, j, k);
            mag_pkg::OP_TRM:
                if (row0) s = pack_set(1, j, k, 0, 0, 0, 1, k, j);
            mag_pkg::OP_ADDM, mag_pkg::OP_SUBM, mag_pkg::OP_PMULM:
                if (row0) s = pack_set(1, j, k, 1, j, k, 1, j, k);
            mag_pkg::OP_ADDV, mag_pkg::OP_SUBV, mag_pkg::OP_PMULV:
                if (plane0) s = pack_set(1, 0, k, 1, 0, k, 1, 0, k);
            mag_pkg::OP_MULSV:
                if (plane0) s = pack_set(1, 0, 0, 1, 0, k, 1, 0, k);
            mag_pkg::OP_DIVVS:
                if (plane0) s = pack_set(1, 0, k, 1, 0, 0, 1, 0, k);
            mag_pkg::OP_MULS, mag_pkg::OP_ADDS, mag_pkg::OP_SUBS:
                if (all0) s = pack_set(1, 0, 0, 1, 0, 0, 1, 0, 0);
            mag_pkg::OP_OPRODV:
                if (row0) s = pack_set(1, 0, j, 1, 0, k, 1, j, k);
            mag_pkg::OP_SUBCMV, mag_pkg::OP_DIVCMV:
                if (row0) s = pack_set(1, j, k, 1, 0, k, 1, j, k);
            mag_pkg::OP_ACCSUMCM:
                if (row0) s = pack_set(1, j, k, 0, 0, 0, 1, 0, k);
            mag_pkg::OP_ABSM, mag_pkg::OP_SETD1:
                if (row0) s = pack_set(1, j, k, 0, 0, 0, 1, j, k);
            mag_pkg::OP_SET0M, mag_pkg::OP_SETIDM:
                if (row0) s = pack_set(0, 0, 0, 0, 0, 0, 1, j, k);
            mag_pkg::OP_ABSV, mag_pkg::OP_SQRTV, mag_pkg::OP_CUTMINV, mag_pkg::OP_COPYV:
                if (plane0) s = pack_set(1, 0, k, 0, 0, 0, 1, 0, k);
            mag_pkg::OP_ABSS, mag_pkg::OP_SQRTS:
                if (all0) s = pack_set(1, 0, 0, 0, 0, 0, 1, 0, 0);
            mag_pkg::OP_DOTV:
                if (red_on)
                begin
                    s = pack_set(1, 0, e, 1, 0, e, 1, 0, 0);
                    s.store_to_reducer = (e + 1 < DIM);
                end
            mag_pkg::OP_SASUM:
                if (red_on)
                begin
                    s = pack_set(1, 0, e, 0, 0, 0, 1, 0, 0);
                    s.store_to_reducer = (e + 1 < DIM);
                end
            default:
                s = '0;
        endcase
        return s;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(string field, mag_pkg::addr_t got, mag_pkg::addr_t want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mag_pkg::addr_set_t want;
        if (!rst_n)
        begin
            expected_sets.delete();
            fail_count = 0;
            pending_results <= 0;
        end
        else
        begin
            // input transfer
            if (in_valid && !in_stall)
                expected_sets.push_back(expected_addr_set(kind, row_idx, mid_idx, col_idx,
                                                          reduce_idx, latency_step));
            // output transfer
            if (out_valid && !out_stall)
            begin
                if (expected_sets.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = expected_sets.pop_front();
                    check_field("load0_valid", mag_pkg::addr_t'(load0_valid),
                                mag_pkg::addr_t'(want.load0_valid));
                    check_field("load0_address", load0_address, want.load0_address);
                    check_field("load1_valid", mag_pkg::addr_t'(load1_valid),
                                mag_pkg::addr_t'(want.load1_valid));
                    check_field("load1_address", load1_address, want.load1_address);
                    check_field("store_valid", mag_pkg::addr_t'(store_valid),
                                mag_pkg::addr_t'(want.store_valid));
                    check_field("store_to_reducer", mag_pkg::addr_t'(store_to_reducer),
                                mag_pkg::addr_t'(want.store_to_reducer));
                    check_field("store_address", store_address, want.store_address);
                end
            end
            pending_results <= expected_sets.size();
        end
    end

endmodule

@@ bench/matrix_op_address_generator_tb.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for the matrix operation address generator
module matrix_op_address_generator_tb;

    localparam int DIM          = 64;
    localparam int RANDOM_ITEMS = 1750;
    localparam int HOLD_CYCLES  = 90;
    localparam int CYCLE_LIMIT  = 200000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    mag_pkg::kind_t    kind;
    mag_pkg::idx_t     row_idx;
    mag_pkg::idx_t     mid_idx;
    mag_pkg::idx_t     col_idx;
    mag_pkg::red_idx_t reduce_idx;
    mag_pkg::lat_t     latency_step;
    logic              out_valid;
    logic              out_stall;
    logic              load0_valid;
    mag_pkg::addr_t    load0_address;
    logic              load1_valid;
    mag_pkg::addr_t    load1_address;
    logic              store_valid;
    logic              store_to_reducer;
    mag_pkg::addr_t    store_address;

    int   fail_count;
    int   pending_results;
    int   cycle_count = 0;
    logic hold_req;
    logic calm;

    matrix_op_address_generator #(.DIM(DIM)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .row_idx(row_idx),
        .mid_idx(mid_idx),
        .col_idx(col_idx),
        .reduce_idx(reduce_idx),
        .latency_step(latency_step),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .load0_valid(load0_valid),
        .load0_address(load0_address),
        .load1_valid(load1_valid),
        .load1_address(load1_address),
        .store_valid(store_valid),
        .store_to_reducer(store_to_reducer),
        .store_address(store_address)
    );

    mag_addr_checker #(.DIM(DIM)) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .row_idx(row_idx),
        .mid_idx(mid_idx),
        .col_idx(col_idx),
        .reduce_idx(reduce_idx),
        .latency_step(latency_step),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .load0_valid(load0_valid),
        .load0_address(load0_address),
        .load1_valid(load1_valid),
        .load1_address(load1_address),
        .store_valid(store_valid),
        .store_to_reducer(store_to_reducer),
        .store_address(store_address),
        .fail_count(fail_count),
        .pending_results(pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver side: one long hold-off, otherwise random stalls unless calm is set
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 17);
        end
    end

    task automatic send_transfer(int op, int i, int j, int k, int e, int lat);
        while (!calm && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        kind         <= mag_pkg::kind_t'(op);
        row_idx      <= mag_pkg::idx_t'(i);
        mid_idx      <= mag_pkg::idx_t'(j);
        col_idx      <= mag_pkg::idx_t'(k);
        reduce_idx   <= mag_pkg::red_idx_t'(e);
        latency_step <= mag_pkg::lat_t'(lat);
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic random_transfer();
        int op;
        int i;
        int j;
        int k;
        int e;
        int lat;
        int r;
        if ($urandom_range(99) < 90)
            op = $urandom_range(int'(mag_pkg::OP_NOOP));
        else
            op = $urandom_range(63, int'(mag_pkg::OP_NOOP) + 1);
        i   = ($urandom_range(99) < 55) ? 0 : $urandom_range(63);
        j   = ($urandom_range(99) < 40) ? 0 : $urandom_range(63);
        k   = ($urandom_range(99) < 25) ? 0 : $urandom_range(63);
        lat = ($urandom_range(99) < 70) ? 0 : $urandom_range(15);
        r   = $urandom_range(99);
        if (r < 15)
            e = DIM - 1;
        else if (r < 70)
            e = $urandom_range(DIM - 1);
        else
            e = $urandom_range(127);
        send_transfer(op, i, j, k, e, lat);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        kind         <= mag_pkg::OP_NOOP;
        row_idx      <= '0;
        mid_idx      <= '0;
        col_idx      <= '0;
        reduce_idx   <= '0;
        latency_step <= '0;
        hold_req     <= 1'b0;
        calm         <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every operation, all indices zero, last reduction element
        for (int op = 0; op <= int'(mag_pkg::OP_NOOP); op++)
            send_transfer(op, 0, 0, 0, DIM - 1, 0);
        send_transfer(int'(mag_pkg::OP_MULMM), 63, 63, 63, 127, 15);
        send_transfer(int'(mag_pkg::OP_MULMM), 0, 0, 0, 0, 0);
        send_transfer(int'(mag_pkg::OP_MULTRMM), 9, 40, 12, 0, 0);
        send_transfer(int'(mag_pkg::OP_MULTRMM), 5, 33, 33, 0, 0);
        send_transfer(int'(mag_pkg::OP_MULTRMV), 0, 20, 19, 0, 0);
        send_transfer(int'(mag_pkg::OP_MULMV), 1, 7, 8, 0, 0);
        send_transfer(int'(mag_pkg::OP_ADDV), 0, 1, 63, 0, 0);
        send_transfer(int'(mag_pkg::OP_MULS), 0, 0, 1, 0, 0);
        send_transfer(int'(mag_pkg::OP_TRM), 0, 63, 0, 0, 0);
        send_transfer(int'(mag_pkg::OP_DOTV), 0, 0, 0, 0, 0);
        send_transfer(int'(mag_pkg::OP_DOTV), 0, 0, 0, DIM, 0);
        send_transfer(int'(mag_pkg::OP_SASUM), 0, 0, 0, DIM - 2, 0);
        send_transfer(int'(mag_pkg::OP_SASUM), 0, 0, 0, DIM - 1, 1);
        send_transfer(63, 0, 0, 0, 0, 0);
        send_transfer(int'(mag_pkg::OP_NOOP) + 1, 63, 63, 63, 127, 15);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 400)
                hold_req <= 1'b1;
            if (n == 900)
            begin
                // drain before going on
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_results != 0);
            end
            if (n == 1200)
                calm <= 1'b1;
            if (n == 1450)
                calm <= 1'b0;
            random_transfer();
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
